@@ design/vrt_pkg.sv @@
`timescale 1ns / 1ps
package vrt_pkg;
  localparam int unsigned CoordW = 16;
  localparam int unsigned TW = 32;
  localparam int unsigned InDataW = 168;   // 3x32 origin, 3x16 dir, 16 max_dist, 1 solid -> 161 -> 168
  localparam int unsigned OutDataW = 96;
  localparam logic [TW-1:0] TMax = '1;

  typedef enum logic [1:0] {
    KindQuery = 2'd0,
    KindHit   = 2'd1,
    KindMiss  = 2'd2
  } kind_e;

  // divider request and response between top and divider
  typedef struct packed {
    logic        start;
    logic [15:0] mag;    // |dir|, 0..32768
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [TW-1:0] quot;
  } div_rsp_t;
endpackage

@@ design/voxel_ray_traversal_top.sv @@
`timescale 1ns / 1ps
// Voxel ray walker, 3D DDA on a unit grid, fixed point.
// s_axis: requests. tuser = mode (0 start ray, 1 occupancy reply).
//   Start carries origin (Q16.16), direction (Q1.14) and max distance (Q8.8).
// m_axis: results. tuser = kind (0 query voxel, 1 hit, 2 miss).
// Each start is answered by a query of the origin voxel; each reply by a
// query of the next voxel, a hit, or a miss. A reply while idle is dropped.
// A start is answered once each axis is set up: one shared restoring divider
// computes 2^30/|d| per axis one quotient bit per cycle (skipped for an
// axis with zero direction), then one 17x32 multiply per axis gives the
// first boundary distance. A reply is answered through StSel (a hit is
// registered at accept): compare of the three boundary distances at
// accept, then step and saturating add.
// The block takes one request at a time; after accept of anything but a dropped
// reply, s_axis_tready is low until the result is taken by m_axis and high again the cycle after.
// A stalled result holds in the output register. Reset drops any walk;
// the block is idle and ready.
module voxel_ray_traversal_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // origin_x[31:0], origin_y[63:32], origin_z[95:64], dir_x[111:96],
  // dir_y[127:112], dir_z[143:128], max_dist[159:144], solid[160], zero fill
  input  logic [vrt_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         s_axis_tuser,   // mode
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // vox_x, vox_y, vox_z, prev_x, prev_y, prev_z, 16 bits each from bit 0
  output logic [vrt_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [1:0]                   m_axis_tuser    // kind
);
  import vrt_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StDivStart, StDivWait, StMul, StSel, StOut
  } state_e;

  state_e        state_q;
  logic [1:0]    axis_q;
  logic          walking_q;
  logic [CoordW-1:0] cur_q [3];
  logic [CoordW-1:0] last_q [3];
  logic [2:0]    neg_q;
  logic [TW-1:0] tnext_q [3];
  logic [TW-1:0] tstep_q [3];
  logic [16:0]   dist_q [3];
  logic [15:0]   limit_q;
  logic [1:0]    sel_q;
  logic [OutDataW-1:0] out_data_q;
  logic [1:0]    out_kind_q;
  logic          out_valid_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic          acc;
  logic [15:0]   dir_s [3];
  logic [15:0]   mag [3];
  logic [47:0]   prod;
  logic [32:0]   sum;
  logic [1:0]    sel_c;
  logic [CoordW-1:0] step_vox;
  logic [CoordW-1:0] next_vox [3];

  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle) && !out_valid_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dir_s[a] = s_axis_tdata[96 + 16*a +: 16];
      mag[a] = dir_s[a][15] ? 16'(-dir_s[a]) : dir_s[a];
    end
  end

  // direction magnitude per axis held for divider start
  logic [15:0] mag_q [3];

  assign div_req.start = (state_q == StDivStart);
  assign div_req.mag = mag_q[axis_q];

  vrt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // dist <= 2^16 and t_step <= 2^30, so the product stays below 2^47
  assign prod = 48'(dist_q[axis_q]) * 48'(tstep_q[axis_q]);

  always_comb begin
    if (tnext_q[0] < tnext_q[1] && tnext_q[0] < tnext_q[2]) sel_c = 2'd0;
    else if (tnext_q[1] < tnext_q[2]) sel_c = 2'd1;
    else sel_c = 2'd2;
  end

  assign sum = {1'b0, tnext_q[sel_q]} + {1'b0, tstep_q[sel_q]};

  assign step_vox = neg_q[sel_q] ? cur_q[sel_q] - 16'd1 : cur_q[sel_q] + 16'd1;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      next_vox[a] = (2'(a) == sel_q) ? step_vox : cur_q[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      axis_q <= '0;
      walking_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_kind_q <= '0;
      out_data_q <= '0;
      sel_q <= '0;
      for (int a = 0; a < 3; a++) begin
        tnext_q[a] <= '0;
        tstep_q[a] <= '0;
      end
    end else begin
      if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (acc) begin
            if (!s_axis_tuser) begin
              axis_q <= 2'd0;
              walking_q <= 1'b1;
              state_q <= StDivStart;
            end else if (walking_q) begin
              if (s_axis_tdata[160]) begin
                walking_q <= 1'b0;
                out_kind_q <= KindHit;
                out_data_q <= {last_q[2], last_q[1], last_q[0],
                               cur_q[2], cur_q[1], cur_q[0]};
                out_valid_q <= 1'b1;
              end else begin
                sel_q <= sel_c;
                state_q <= StSel;
              end
            end
          end
        end
        StDivStart: begin
          state_q <= (mag_q[axis_q] == '0) ? StMul : StDivWait;
          if (mag_q[axis_q] == '0) tstep_q[axis_q] <= TMax;
        end
        StDivWait: begin
          if (div_rsp.done) begin
            tstep_q[axis_q] <= div_rsp.quot;
            state_q <= StMul;
          end
        end
        StMul: begin
          if (mag_q[axis_q] == '0) tnext_q[axis_q] <= TMax;
          else tnext_q[axis_q] <= prod[47:16];
          if (axis_q == 2'd2) begin
            out_kind_q <= KindQuery;
            out_data_q <= {cur_q[2], cur_q[1], cur_q[0],
                           cur_q[2], cur_q[1], cur_q[0]};
            out_valid_q <= 1'b1;
            state_q <= StOut;
          end else begin
            axis_q <= axis_q + 2'd1;
            state_q <= StDivStart;
          end
        end
        StSel: begin
          tnext_q[sel_q] <= sum[32] ? TMax : sum[31:0];
          if (tnext_q[sel_q] <= {limit_q, 8'd0}) begin
            out_kind_q <= KindQuery;
            out_data_q <= {cur_q[2], cur_q[1], cur_q[0],
                           next_vox[2], next_vox[1], next_vox[0]};
          end else begin
            walking_q <= 1'b0;
            out_kind_q <= KindMiss;
            out_data_q <= '0;
          end
          out_valid_q <= 1'b1;
          state_q <= StOut;
        end
        StOut: begin
          if (!out_valid_q || m_axis_tready) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // start-time setup of per-axis registers, voxel step on a reply
  always_ff @(posedge clk_i) begin
    if (acc && !s_axis_tuser) begin
      for (int a = 0; a < 3; a++) begin
        logic [31:0] o;
        o = s_axis_tdata[32*a +: 32] + 32'h8000;
        cur_q[a] <= o[31:16];
        last_q[a] <= o[31:16];
        neg_q[a] <= dir_s[a][15] || (dir_s[a] == '0);
        mag_q[a] <= mag[a];
        dist_q[a] <= dir_s[a][15] ? {1'b0, o[15:0]} : 17'h10000 - {1'b0, o[15:0]};
      end
      limit_q <= s_axis_tdata[159:144];
    end else if (state_q == StSel) begin
      for (int a = 0; a < 3; a++) begin
        last_q[a] <= cur_q[a];
        cur_q[a] <= next_vox[a];
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_kind_q;
endmodule

@@ design/vrt_div.sv @@
`timescale 1ns / 1ps
// restoring divider: 2^30 / mag, one quotient bit per cycle
module vrt_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vrt_pkg::div_req_t req_i,
  output vrt_pkg::div_rsp_t rsp_o
);
  import vrt_pkg::*;

  localparam int unsigned NumBits = 31;

  logic [4:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [15:0]   rem_q, rem_d;
  logic [TW-1:0] quot_q, quot_d;
  logic [15:0]   den_q, den_d;
  logic [16:0]   shifted;
  logic          num_bit;

  always_comb begin
    num_bit = (cnt_q == 5'd30);
    shifted = {rem_q, num_bit};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    rem_d = rem_q;
    quot_d = quot_q;
    den_d = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d = 5'(NumBits - 1);
      rem_d = '0;
      quot_d = '0;
      den_d = req_i.mag;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = 16'(shifted - {1'b0, den_q});
        quot_d = {quot_q[TW-2:0], 1'b1};
      end else begin
        rem_d = shifted[15:0];
        quot_d = {quot_q[TW-2:0], 1'b0};
      end
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quot_q <= quot_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
endmodule
